FILE: design/jacobi_linear_solver_defines.svh
// ----------------------------------------------------------------------------
// Jacobi solver assertion macros
// Shared property forms for the solver checker.
// ----------------------------------------------------------------------------
`ifndef JACOBI_LINEAR_SOLVER_DEFINES_SVH
`define JACOBI_LINEAR_SOLVER_DEFINES_SVH

// Same-cycle implication, sampled on clock, inactive during reset.
`define JLS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("jacobi solver check failed");

// Next-cycle implication, sampled on clock, inactive during reset.
`define JLS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("jacobi solver check failed");

`endif

FILE: design/jls_pkg.sv
// ----------------------------------------------------------------------------
// Jacobi solver package
// Number format, index widths, request codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package jls_pkg;

   localparam int MAX_UNKNOWNS   = 64;
   localparam int VALUE_BITS     = 40;
   localparam int FRACTION_BITS  = 16;
   localparam int IDX_BITS       = $clog2(MAX_UNKNOWNS);
   localparam int COUNT_BITS     = $clog2(MAX_UNKNOWNS + 1);
   localparam int COEF_ADDR_BITS = 2 * IDX_BITS;
   localparam int SWEEP_BITS     = 16;
   localparam int TOL_BITS       = VALUE_BITS - 1;
   localparam int CSR_IDX_BITS   = 2;
   localparam int CSR_DATA_BITS  = TOL_BITS;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   localparam value_type VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam value_type VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_COEF  = 2'd0,
      OP_RHS   = 2'd1,
      OP_SOLVE = 2'd2
   } op_type;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNKNOWNS   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_SWEEPS = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOLERANCE  = 2'd2;

   localparam logic [COUNT_BITS-1:0] UNKNOWNS_RESET   = COUNT_BITS'(MAX_UNKNOWNS);
   localparam logic [SWEEP_BITS-1:0] MAX_SWEEPS_RESET = 16'd100;
   localparam logic [TOL_BITS-1:0]   TOLERANCE_RESET  = TOL_BITS'(1);

   // Handshake between the sequencer and the multiplier pipeline.
   typedef struct packed {
      logic      valid;
      value_type product;
      logic      busy;
   } mac_status_type;

endpackage

`default_nettype wire

FILE: design/jls_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module jls_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: design/jls_mac.sv
// ----------------------------------------------------------------------------
// Jacobi solver product pipeline
// Two-stage fixed-point multiply: partial products, then combine, scale and
// saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module jls_mac (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire jls_pkg::value_type     coef,
   input  wire jls_pkg::value_type     x,
   output jls_pkg::mac_status_type     status
);
   import jls_pkg::*;

   localparam int LO_BITS   = VALUE_BITS / 2;
   localparam int HI_BITS   = VALUE_BITS - LO_BITS;
   localparam int WIDE_BITS = 2 * VALUE_BITS;

   typedef logic [WIDE_BITS-1:0] wide_type;

   logic [VALUE_BITS-1:0] a_mag, b_mag;
   logic s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic s1_neg_ff;
   logic [2*LO_BITS-1:0]       pll_ff;
   logic [LO_BITS+HI_BITS-1:0] plh_ff, phl_ff;
   logic [2*HI_BITS-1:0]       phh_ff;
   value_type prod_ff, prod_in;
   wide_type  full, scaled, limit, mag;

   assign a_mag = coef[VALUE_BITS-1] ? (~coef + 1'b1) : coef;
   assign b_mag = x[VALUE_BITS-1] ? (~x + 1'b1) : x;

   assign s1_valid_in = in_valid;
   assign s2_valid_in = s1_valid_ff;

   always_comb begin
      full = wide_type'(pll_ff) + (wide_type'(plh_ff) << LO_BITS)
           + (wide_type'(phl_ff) << LO_BITS) + (wide_type'(phh_ff) << (2 * LO_BITS));
      scaled = full >> FRACTION_BITS;
      // A negative result may reach one past the positive limit.
      limit = s1_neg_ff ? (wide_type'(1) << (VALUE_BITS - 1))
                        : ((wide_type'(1) << (VALUE_BITS - 1)) - 1'b1);
      mag = (scaled > limit) ? limit : scaled;
      prod_in = s1_neg_ff ? value_type'(~mag[VALUE_BITS-1:0] + 1'b1)
                          : value_type'(mag[VALUE_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_neg_ff <= coef[VALUE_BITS-1] ^ x[VALUE_BITS-1];
      pll_ff    <= a_mag[LO_BITS-1:0] * b_mag[LO_BITS-1:0];
      plh_ff    <= a_mag[LO_BITS-1:0] * b_mag[VALUE_BITS-1:LO_BITS];
      phl_ff    <= a_mag[VALUE_BITS-1:LO_BITS] * b_mag[LO_BITS-1:0];
      phh_ff    <= a_mag[VALUE_BITS-1:LO_BITS] * b_mag[VALUE_BITS-1:LO_BITS];
      prod_ff   <= prod_in;
   end

   assign status.valid   = s2_valid_ff;
   assign status.product = prod_ff;
   assign status.busy    = s1_valid_ff | s2_valid_ff;

endmodule

`default_nettype wire

FILE: design/jls_div.sv
// ----------------------------------------------------------------------------
// Jacobi solver divider
// Restoring division, one quotient bit per cycle, scaled and saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module jls_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire jls_pkg::value_type numer,
   input  wire jls_pkg::value_type denom,
   output logic                    done,
   output jls_pkg::value_type      quotient
);
   import jls_pkg::*;

   localparam int NUM_BITS = VALUE_BITS + FRACTION_BITS;
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_BUSY,
      DV_FINISH
   } dv_state_type;

   dv_state_type state_ff, state_in;
   logic [NUM_BITS-1:0]   num_ff, num_in, q_ff, q_in, limit;
   logic [VALUE_BITS:0]   rem_ff, rem_in, shifted;
   logic [VALUE_BITS-1:0] dm_ff, dm_in, n_mag, d_mag, sat;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic neg_ff, neg_in, done_ff, done_in;
   value_type quot_ff, quot_in;

   assign n_mag = numer[VALUE_BITS-1] ? (~numer + 1'b1) : numer;
   assign d_mag = denom[VALUE_BITS-1] ? (~denom + 1'b1) : denom;

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      dm_in    = dm_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      quot_in  = quot_ff;
      shifted  = {rem_ff[VALUE_BITS-1:0], num_ff[NUM_BITS-1]};
      limit    = neg_ff ? (NUM_BITS'(1) << (VALUE_BITS - 1))
                        : ((NUM_BITS'(1) << (VALUE_BITS - 1)) - 1'b1);
      sat      = (q_ff > limit) ? limit[VALUE_BITS-1:0] : q_ff[VALUE_BITS-1:0];
      unique case (state_ff)
         DV_IDLE: begin
            if (start) begin
               num_in   = {n_mag, {FRACTION_BITS{1'b0}}};
               q_in     = '0;
               rem_in   = '0;
               dm_in    = d_mag;
               neg_in   = numer[VALUE_BITS-1] ^ denom[VALUE_BITS-1];
               cnt_in   = CNT_BITS'(NUM_BITS);
               state_in = DV_BUSY;
            end
         end
         DV_BUSY: begin
            if (shifted >= {1'b0, dm_ff}) begin
               rem_in = shifted - {1'b0, dm_ff};
               q_in   = {q_ff[NUM_BITS-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               q_in   = {q_ff[NUM_BITS-2:0], 1'b0};
            end
            num_in = num_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               state_in = DV_FINISH;
            end
         end
         DV_FINISH: begin
            quot_in  = neg_ff ? value_type'(~sat + 1'b1) : value_type'(sat);
            done_in  = 1'b1;
            state_in = DV_IDLE;
         end
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      num_ff  <= num_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dm_ff   <= dm_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

FILE: design/jacobi_linear_solver.sv
// ----------------------------------------------------------------------------
// Jacobi linear solver
// Fixed-point Jacobi iteration over coefficient, rhs and solution memories.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_* with valid/ready. A coefficient or rhs
// request is taken while the block is idle and writes its memory. A solve
// request starts from a zero solution and runs sweeps until every unknown
// moves by less than the tolerance or the sweep limit is hit; then one
// response per unknown leaves on rsp_* in index order, the final one with
// rsp_last set. The user writes the size, sweep limit and tolerance on csr_*
// only while idle; the block itself does not enforce it. Sequence: each row
// of a sweep issues and drains its products, then goes through the
// bit-serial divider (skipped when the diagonal is zero) and writes the
// result; each response is then read, loaded and held until the receiver is
// ready. The divider and the single read port of the coefficient memory
// bound the speed of a sweep. req_ready is low from the solve request until
// the last response is taken. A stalled receiver holds the response register
// and the block waits. Reset returns the block to idle with the register
// defaults; memories are not cleared, and the first sweep reads zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_linear_solver (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [1:0]                           req_op,
   input  wire logic [jls_pkg::IDX_BITS-1:0]         req_row,
   input  wire logic [jls_pkg::IDX_BITS-1:0]         req_col,
   input  wire jls_pkg::value_type                   req_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [jls_pkg::IDX_BITS-1:0]              rsp_unknown_index,
   output jls_pkg::value_type                        rsp_solution,
   output logic                                      rsp_last,
   output logic [jls_pkg::SWEEP_BITS-1:0]            rsp_sweeps_done,
   output logic                                      rsp_converged,
   output logic                                      rsp_divide_error,
   input  wire logic                                 csr_write_enable,
   input  wire logic [jls_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [jls_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import jls_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROW,
      ST_ISSUE,
      ST_DRAIN,
      ST_DIVIDE,
      ST_DIV_WAIT,
      ST_WRITE,
      ST_SWEEP_END,
      ST_EMIT_RD,
      ST_EMIT_LOAD,
      ST_EMIT_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [COUNT_BITS-1:0] cfg_n_ff, cfg_n_in;
   logic [SWEEP_BITS-1:0] cfg_lim_ff, cfg_lim_in;
   logic [TOL_BITS-1:0]   cfg_tol_ff, cfg_tol_in;
   logic [IDX_BITS-1:0]   i_ff, i_in, j_ff, j_in, k_ff, k_in, nlast_ff, nlast_in;
   logic [IDX_BITS-1:0]   j1_ff, j1_in, rd_idx;
   logic [SWEEP_BITS-1:0] lim_ff, lim_in, sweeps_ff, sweeps_in;
   logic v1_ff, v1_in, first_ff, first_in, sel_ff, sel_in;
   logic all_ok_ff, all_ok_in, zdiv_ff, zdiv_in, conv_ff, conv_in;
   value_type acc_ff, acc_in, diag_ff, diag_in, prev_i_ff, prev_i_in, res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0]   rsp_idx_ff, rsp_idx_in;
   value_type             rsp_sol_ff, rsp_sol_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [COUNT_BITS-1:0] n_eff;
   logic [SWEEP_BITS:0]   sweeps_next;
   logic coef_we, rhs_we, sol_we, req_fire, div_start, div_done;
   value_type coef_rd, rhs_rd, bank0_rd, bank1_rd, prev_rd, prev_x, div_q;
   logic [VALUE_BITS:0] sub_wide, diff_wide, diff_mag;
   mac_status_type mac;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign coef_we   = req_fire & (op_type'(req_op) == OP_COEF);
   assign rhs_we    = req_fire & (op_type'(req_op) == OP_RHS);
   assign sol_we    = (state_ff == ST_WRITE);
   assign rd_idx    = (state_ff == ST_ISSUE) ? j_ff : k_ff;
   assign prev_rd   = sel_ff ? bank0_rd : bank1_rd;
   // The first sweep starts from an all-zero solution.
   assign prev_x    = first_ff ? value_type'(0) : prev_rd;

   jls_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_UNKNOWNS * MAX_UNKNOWNS)) u_coef_ram (
      .clock (clock),
      .we    (coef_we),
      .waddr ({req_row, req_col}),
      .wdata (req_value),
      .raddr ({i_ff, j_ff}),
      .rdata (coef_rd)
   );

   jls_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_UNKNOWNS)) u_rhs_ram (
      .clock (clock),
      .we    (rhs_we),
      .waddr (req_row),
      .wdata (req_value),
      .raddr (i_ff),
      .rdata (rhs_rd)
   );

   jls_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_UNKNOWNS)) u_sol_bank0 (
      .clock (clock),
      .we    (sol_we & ~sel_ff),
      .waddr (i_ff),
      .wdata (res_ff),
      .raddr (rd_idx),
      .rdata (bank0_rd)
   );

   jls_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_UNKNOWNS)) u_sol_bank1 (
      .clock (clock),
      .we    (sol_we & sel_ff),
      .waddr (i_ff),
      .wdata (res_ff),
      .raddr (rd_idx),
      .rdata (bank1_rd)
   );

   jls_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v1_ff && (j1_ff != i_ff)),
      .coef     (coef_rd),
      .x        (prev_x),
      .status   (mac)
   );

   jls_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (acc_ff),
      .denom    (diag_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      if (cfg_n_ff == '0) begin
         n_eff = COUNT_BITS'(1);
      end else if (cfg_n_ff > COUNT_BITS'(MAX_UNKNOWNS)) begin
         n_eff = COUNT_BITS'(MAX_UNKNOWNS);
      end else begin
         n_eff = cfg_n_ff;
      end
      sub_wide    = {acc_ff[VALUE_BITS-1], acc_ff}
                  - {mac.product[VALUE_BITS-1], mac.product};
      diff_wide   = {res_ff[VALUE_BITS-1], res_ff} - {prev_i_ff[VALUE_BITS-1], prev_i_ff};
      diff_mag    = diff_wide[VALUE_BITS] ? (~diff_wide + 1'b1) : diff_wide;
      sweeps_next = {1'b0, sweeps_ff} + 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      cfg_n_in     = cfg_n_ff;
      cfg_lim_in   = cfg_lim_ff;
      cfg_tol_in   = cfg_tol_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      nlast_in     = nlast_ff;
      j1_in        = j_ff;
      v1_in        = 1'b0;
      lim_in       = lim_ff;
      sweeps_in    = sweeps_ff;
      first_in     = first_ff;
      sel_in       = sel_ff;
      all_ok_in    = all_ok_ff;
      zdiv_in      = zdiv_ff;
      conv_in      = conv_ff;
      acc_in       = acc_ff;
      diag_in      = diag_ff;
      prev_i_in    = prev_i_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_sol_in   = rsp_sol_ff;
      rsp_last_in  = rsp_last_ff;
      div_start    = 1'b0;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_UNKNOWNS:   cfg_n_in   = csr_write_data[COUNT_BITS-1:0];
            CSR_MAX_SWEEPS: cfg_lim_in = csr_write_data[SWEEP_BITS-1:0];
            CSR_TOLERANCE:  cfg_tol_in = csr_write_data[TOL_BITS-1:0];
            default: ;
         endcase
      end

      // Read data for the product issued in the previous cycle.
      if (v1_ff && (j1_ff == i_ff)) begin
         diag_in   = coef_rd;
         prev_i_in = prev_x;
      end
      if (mac.valid) begin
         if (sub_wide[VALUE_BITS] != sub_wide[VALUE_BITS-1]) begin
            acc_in = sub_wide[VALUE_BITS] ? VALUE_MIN : VALUE_MAX;
         end else begin
            acc_in = value_type'(sub_wide[VALUE_BITS-1:0]);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (op_type'(req_op) == OP_SOLVE)) begin
               nlast_in  = IDX_BITS'(n_eff - 1'b1);
               lim_in    = (cfg_lim_ff == '0) ? SWEEP_BITS'(1) : cfg_lim_ff;
               i_in      = '0;
               sweeps_in = '0;
               first_in  = 1'b1;
               zdiv_in   = 1'b0;
               all_ok_in = 1'b1;
               state_in  = ST_ROW;
            end
         end
         ST_ROW: begin
            j_in     = '0;
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            if (j_ff == '0) begin
               acc_in = rhs_rd;
            end
            v1_in = 1'b1;
            j_in  = j_ff + 1'b1;
            if (j_ff == nlast_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !mac.busy) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (diag_ff == '0) begin
               zdiv_in = 1'b1;
               if (acc_ff == '0) begin
                  res_in = '0;
               end else begin
                  res_in = acc_ff[VALUE_BITS-1] ? VALUE_MIN : VALUE_MAX;
               end
               state_in = ST_WRITE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               res_in   = div_q;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (diff_mag >= {2'b00, cfg_tol_ff}) begin
               all_ok_in = 1'b0;
            end
            if (i_ff == nlast_ff) begin
               state_in = ST_SWEEP_END;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_ROW;
            end
         end
         ST_SWEEP_END: begin
            sweeps_in = sweeps_next[SWEEP_BITS-1:0];
            sel_in    = ~sel_ff;
            first_in  = 1'b0;
            if (all_ok_ff || (sweeps_next >= {1'b0, lim_ff})) begin
               conv_in  = all_ok_ff;
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end else begin
               all_ok_in = 1'b1;
               i_in      = '0;
               state_in  = ST_ROW;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_idx_in   = k_ff;
            rsp_sol_in   = prev_rd;
            rsp_last_in  = (k_ff == nlast_ff);
            state_in     = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_n_ff     <= UNKNOWNS_RESET;
         cfg_lim_ff   <= MAX_SWEEPS_RESET;
         cfg_tol_ff   <= TOLERANCE_RESET;
         v1_ff        <= 1'b0;
         sweeps_ff    <= '0;
         first_ff     <= 1'b1;
         sel_ff       <= 1'b0;
         zdiv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_n_ff     <= cfg_n_in;
         cfg_lim_ff   <= cfg_lim_in;
         cfg_tol_ff   <= cfg_tol_in;
         v1_ff        <= v1_in;
         sweeps_ff    <= sweeps_in;
         first_ff     <= first_in;
         sel_ff       <= sel_in;
         zdiv_ff      <= zdiv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      nlast_ff    <= nlast_in;
      j1_ff       <= j1_in;
      lim_ff      <= lim_in;
      all_ok_ff   <= all_ok_in;
      conv_ff     <= conv_in;
      acc_ff      <= acc_in;
      diag_ff     <= diag_in;
      prev_i_ff   <= prev_i_in;
      res_ff      <= res_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_sol_ff  <= rsp_sol_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_unknown_index = rsp_idx_ff;
   assign rsp_solution      = rsp_sol_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_sweeps_done   = sweeps_ff;
   assign rsp_converged     = conv_ff;
   assign rsp_divide_error  = zdiv_ff;

endmodule

`default_nettype wire

FILE: design/jls_checker.sv
// ----------------------------------------------------------------------------
// Jacobi solver port checker
// Assertions on the solver's ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "jacobi_linear_solver_defines.svh"

module jls_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 req_valid,
   input wire logic                                 req_ready,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire jls_pkg::value_type                   rsp_solution,
   input wire logic                                 rsp_last,
   input wire logic [jls_pkg::SWEEP_BITS-1:0]       rsp_sweeps_done
);

   // A stalled response keeps its value.
   `JLS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_solution))

   // Requests are never taken while responses are pending.
   `JLS_ASSERT_SAME(a_no_overlap, req_valid && req_ready, !rsp_valid)

   // After a response that is not the last, the block is still busy.
   `JLS_ASSERT_NEXT(a_busy_mid_run, rsp_valid && rsp_ready && !rsp_last, !req_ready)

   // Every solve runs at least one sweep.
   `JLS_ASSERT_SAME(a_sweeps_nonzero, rsp_valid, rsp_sweeps_done != '0)

endmodule

bind jacobi_linear_solver jls_checker u_jls_checker (.*);

`default_nettype wire
